### hdl/dptt_pkg.sv
// Package for the depth-preferred transposition table: sizes, codes and the
// structs that pass between the front end, the back end and the table RAM.
// No dependencies.
package dptt_pkg;

    localparam int INDEX_BITS = 10;
    localparam int TABLE_SIZE = 1 << INDEX_BITS;

    localparam int HASH_BITS  = 64;
    localparam int DEPTH_BITS = 6;
    localparam int SCORE_BITS = 16;
    localparam int MOVE_BITS  = 16;
    localparam int FLAG_BITS  = 4;
    localparam int BOUND_BITS = 2;

    // Command queue between front end and back end.
    localparam int QDEPTH    = 2;
    localparam int QPTR_BITS = 1;
    localparam int QCNT_BITS = 2;

    localparam int IN_DATA_BITS  = 144;
    localparam int OUT_DATA_BITS = 48;

    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_STORE  = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    localparam logic [BOUND_BITS-1:0] BOUND_EXACT = 2'd0;
    localparam logic [BOUND_BITS-1:0] BOUND_LOWER = 2'd1;
    localparam logic [BOUND_BITS-1:0] BOUND_UPPER = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL
    } state_t;

    // Input word as packed on the slave tdata; the last field declared here sits in the lowest bits.
    typedef struct packed {
        logic [4:0]                   pad;
        logic [FLAG_BITS-1:0]         move_flags;
        logic [MOVE_BITS-1:0]         move_code;
        logic signed [SCORE_BITS-1:0] beta;
        logic signed [SCORE_BITS-1:0] alpha;
        logic signed [SCORE_BITS-1:0] score;
        logic                         eval_only;
        logic [DEPTH_BITS-1:0]        remaining_depth;
        logic [HASH_BITS-1:0]         position_hash;
    } in_word_t;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        action_t                      action;
        logic [HASH_BITS-1:0]         hash;
        logic [DEPTH_BITS-1:0]        req_depth;
        logic                         eval_only;
        logic [BOUND_BITS-1:0]        bound;
        logic signed [SCORE_BITS-1:0] score;
        logic [MOVE_BITS-1:0]         move_code;
        logic [FLAG_BITS-1:0]         move_flags;
    } cmd_t;

    // One table entry. A depth of minus one marks the entry empty.
    typedef struct packed {
        logic [HASH_BITS-1:0]         tag;
        logic signed [DEPTH_BITS:0]   depth;
        logic signed [SCORE_BITS-1:0] score;
        logic [MOVE_BITS-1:0]         move_code;
        logic [FLAG_BITS-1:0]         move_flags;
        logic [BOUND_BITS-1:0]        bound;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    localparam entry_t EMPTY_ENTRY = '{
        tag:        '0,
        depth:      '1,
        score:      '0,
        move_code:  '0,
        move_flags: '0,
        bound:      '0
    };

    // Result word; the last field declared here sits in the lowest bits.
    typedef struct packed {
        logic                         written;
        logic [FLAG_BITS-1:0]         stored_move_flags;
        logic [MOVE_BITS-1:0]         stored_move_code;
        logic signed [SCORE_BITS-1:0] stored_score;
        logic [BOUND_BITS-1:0]        bound_kind;
        logic [DEPTH_BITS-1:0]        stored_depth;
        logic                         hit;
    } result_t;

    // Status from the back end to the front end.
    typedef struct packed {
        logic init_busy;
    } back_status_t;

endpackage

### hdl/depth_preferred_transposition_table.sv
// Depth-preferred transposition table, top level. A lookup or store gives a registered
// result word; the back end finishes each lookup or store, one table RAM read and, if it
// replaces, one write-back, before it takes the next command. A clear sweeps all 1024
// entries. After reset the table sweeps itself empty, with s_axis_tready low.
// Uses dptt_pkg, dptt_front, dptt_back and dptt_ram.
module depth_preferred_transposition_table
    import dptt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // tdata from bit 0: position_hash[63:0], remaining_depth[69:64], eval_only[70],
    // score[86:71], alpha[102:87], beta[118:103], move_code[134:119],
    // move_flags[138:135], zero fill[143:139].
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    // tuser: action (0 lookup, 1 store, 2 clear, 3 no operation).
    input  logic [1:0]               s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // tdata from bit 0: hit[0], stored_depth[6:1], bound_kind[8:7],
    // stored_score[24:9], stored_move_code[40:25], stored_move_flags[44:41],
    // written[45], zero fill[47:46].
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata
);

    // The front end decodes each incoming word and classifies its bound while
    // the back end may still be busy with an earlier command; the two-entry
    // command queue between them lets either side stall on its own.
    logic         cmd_valid;
    logic         cmd_pop;
    cmd_t         cmd;
    back_status_t back_status;
    result_t      result;

    dptt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_word     (in_word_t'(s_axis_tdata)),
        .in_action   (action_t'(s_axis_tuser)),
        .back_status (back_status),
        .cmd_valid   (cmd_valid),
        .cmd_pop     (cmd_pop),
        .cmd         (cmd)
    );

    // The back end owns the table RAM. Each entry holds the full hash as a
    // tag, so a lookup is a tag compare plus a depth check (skipped for eval-only); a store
    // writes back only when it carries a move (nonzero flags) and the offered depth is deeper than the stored one.
    dptt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_pop     (cmd_pop),
        .cmd         (cmd),
        .back_status (back_status),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_result  (result)
    );

    assign m_axis_tdata = {2'b00, result};

    // No word is taken while the table is still being emptied after reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        back_status.init_busy |-> !s_axis_tready)
        else $error("input accepted during reset sweep");

    // A result word never reports both a hit and a write.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(result.hit && result.written))
        else $error("result reports hit and write together");

    // A word without a hit carries no entry contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !result.hit) |-> (m_axis_tdata[44:1] == '0))
        else $error("miss or write result carries entry data");

    // The back end only takes a command that the queue actually holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

endmodule

### hdl/dptt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module dptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hdl/dptt_front.sv
// Front end: accepts input words, classifies the bound of a store and
// queues the resulting commands for the back end. Uses dptt_pkg.
module dptt_front
    import dptt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  in_word_t     in_word,
    input  action_t      in_action,
    input  back_status_t back_status,
    output logic         cmd_valid,
    input  logic         cmd_pop,
    output cmd_t         cmd
);

    cmd_t                 q_mem_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    cmd_t                 new_cmd;
    logic                 push;

    // Beta is tested first, so an inverted window still gives a lower bound.
    always_comb
    begin
        new_cmd.action     = in_action;
        new_cmd.hash       = in_word.position_hash;
        new_cmd.req_depth  = in_word.remaining_depth;
        new_cmd.eval_only  = in_word.eval_only;
        new_cmd.score      = in_word.score;
        new_cmd.move_code  = in_word.move_code;
        new_cmd.move_flags = in_word.move_flags;
        if (in_word.score >= in_word.beta)
        begin
            new_cmd.bound = BOUND_LOWER;
        end
        else if (in_word.score <= in_word.alpha)
        begin
            new_cmd.bound = BOUND_UPPER;
        end
        else
        begin
            new_cmd.bound = BOUND_EXACT;
        end
    end

    assign in_ready  = (count_reg != QCNT_BITS'(QDEPTH)) && !back_status.init_busy;
    assign push      = in_valid && in_ready;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_BITS'(push) - QCNT_BITS'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

### hdl/dptt_back.sv
// Back end: reads the table RAM for each queued lookup or store and writes back a
// replacing store, sweeps the table on clear, and holds the result word.
// Uses dptt_pkg and dptt_ram.
module dptt_back
    import dptt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cmd_valid,
    output logic         cmd_pop,
    input  cmd_t         cmd,
    output back_status_t back_status,
    output logic         out_valid,
    input  logic         out_ready,
    output result_t      out_result
);

    state_t                  state_reg, state_next;
    logic [INDEX_BITS-1:0]   clr_cnt_reg, clr_cnt_next;
    logic                    clr_report_reg, clr_report_next;
    cmd_t                    cur_reg, cur_next;
    logic                    out_valid_reg, out_valid_next;
    result_t                 out_data_reg, out_data_next;

    logic                    ram_we;
    logic [INDEX_BITS-1:0]   ram_waddr;
    entry_t                  ram_wdata;
    logic                    ram_re;
    logic [INDEX_BITS-1:0]   ram_raddr;
    entry_t                  ram_rdata;

    logic                    slot_free;
    logic                    clr_last;
    logic                    load;
    result_t                 load_val;
    logic                    hit;
    logic                    replace;

    dptt_ram #(
        .WIDTH(ENTRY_BITS),
        .DEPTH(TABLE_SIZE)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign slot_free = !out_valid_reg || out_ready;
    assign clr_last  = (clr_cnt_reg == INDEX_BITS'(TABLE_SIZE - 1));

    // An empty entry has a negative depth, so it never hits.
    assign hit = !ram_rdata.depth[DEPTH_BITS]
              && (ram_rdata.tag == cur_reg.hash)
              && (cur_reg.eval_only
                  || (ram_rdata.depth[DEPTH_BITS-1:0] >= cur_reg.req_depth));
    assign replace = (cur_reg.move_flags != '0)
                  && (ram_rdata.depth < $signed({1'b0, cur_reg.req_depth}));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid && slot_free)
                begin
                    unique case (cmd.action)
                        ACT_LOOKUP, ACT_STORE: state_next = ST_EVAL;
                        ACT_CLEAR:             state_next = ST_CLEAR;
                        ACT_NONE:              state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EVAL:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ram_we          = 1'b0;
        ram_waddr       = clr_cnt_reg;
        ram_wdata       = EMPTY_ENTRY;
        ram_re          = 1'b0;
        ram_raddr       = cmd.hash[INDEX_BITS-1:0];
        cmd_pop         = 1'b0;
        load            = 1'b0;
        load_val        = '0;
        clr_cnt_next    = clr_cnt_reg;
        clr_report_next = clr_report_reg;
        cur_next        = cur_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_last)
                begin
                    clr_report_next = 1'b0;
                    if (clr_report_reg)
                    begin
                        load             = 1'b1;
                        load_val.written = 1'b1;
                    end
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid && slot_free)
                begin
                    cmd_pop  = 1'b1;
                    cur_next = cmd;
                    unique case (cmd.action)
                        ACT_LOOKUP, ACT_STORE: ram_re = 1'b1;
                        ACT_CLEAR:             clr_report_next = 1'b1;
                        ACT_NONE:              load = 1'b1;
                    endcase
                end
            end
            ST_EVAL:
            begin
                load = 1'b1;
                if (cur_reg.action == ACT_LOOKUP)
                begin
                    if (hit)
                    begin
                        load_val.hit               = 1'b1;
                        load_val.stored_depth      = ram_rdata.depth[DEPTH_BITS-1:0];
                        load_val.bound_kind        = ram_rdata.bound;
                        load_val.stored_score      = ram_rdata.score;
                        load_val.stored_move_code  = ram_rdata.move_code;
                        load_val.stored_move_flags = ram_rdata.move_flags;
                    end
                end
                else if (replace)
                begin
                    ram_we               = 1'b1;
                    ram_waddr            = cur_reg.hash[INDEX_BITS-1:0];
                    ram_wdata.tag        = cur_reg.hash;
                    ram_wdata.depth      = $signed({1'b0, cur_reg.req_depth});
                    ram_wdata.score      = cur_reg.score;
                    ram_wdata.move_code  = cur_reg.move_code;
                    ram_wdata.move_flags = cur_reg.move_flags;
                    ram_wdata.bound      = cur_reg.bound;
                    load_val.written     = 1'b1;
                end
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
        out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        out_data_next  = load ? load_val : out_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            clr_report_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            clr_report_reg <= clr_report_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_data_reg <= out_data_next;
    end

    assign back_status.init_busy = (state_reg == ST_CLEAR) && !clr_report_reg;
    assign out_valid             = out_valid_reg;
    assign out_result            = out_data_reg;

endmodule

### tb/tb.sv
// Testbench for the depth-preferred transposition table: directed and random lookups,
// stores, clears and no-ops checked word by word against an in-bench table predictor.
// Depends on dptt_pkg and the depth_preferred_transposition_table RTL only.
module tb;
    import dptt_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 1030;
    localparam int POOL         = 8;
    localparam int HI_BITS      = HASH_BITS - INDEX_BITS;

    // Scoreboard: keeps its own copy of the table, predicts the reply word of every
    // accepted command and compares each delivered reply with the oldest prediction.
    class dptt_scoreboard;
        logic [HASH_BITS-1:0]         tag_mem   [TABLE_SIZE];
        logic signed [DEPTH_BITS:0]   depth_mem [TABLE_SIZE];
        logic signed [SCORE_BITS-1:0] score_mem [TABLE_SIZE];
        logic [MOVE_BITS-1:0]         move_mem  [TABLE_SIZE];
        logic [FLAG_BITS-1:0]         flags_mem [TABLE_SIZE];
        logic [BOUND_BITS-1:0]        bound_mem [TABLE_SIZE];
        // Set once a store has written the tag, so only such entries are ever looked up.
        bit                           tag_known [TABLE_SIZE];
        result_t                      awaited_replies [$];
        int mismatches;
        int lookups;
        int hits;
        int replaced;
        int clears;

        function new();
            for (int i = 0; i < TABLE_SIZE; i++)
            begin
                depth_mem[i] = '1;
                tag_known[i] = 1'b0;
            end
        endfunction

        function void note_command(action_t act, in_word_t w);
            result_t                      r;
            logic [INDEX_BITS-1:0]        idx;
            logic signed [DEPTH_BITS:0]   offered;
            logic signed [SCORE_BITS-1:0] sc;
            logic signed [SCORE_BITS-1:0] lo;
            logic signed [SCORE_BITS-1:0] hi;
            r       = '0;
            idx     = w.position_hash[INDEX_BITS-1:0];
            offered = $signed({1'b0, w.remaining_depth});
            sc      = w.score;
            lo      = w.alpha;
            hi      = w.beta;
            case (act)
                ACT_LOOKUP:
                begin
                    lookups++;
                    // An empty entry never hits, not even for an eval-only lookup.
                    if (depth_mem[idx] >= 0 && tag_mem[idx] == w.position_hash &&
                        (w.eval_only || depth_mem[idx] >= offered))
                    begin
                        hits++;
                        r.hit               = 1'b1;
                        r.stored_depth      = depth_mem[idx][DEPTH_BITS-1:0];
                        r.bound_kind        = bound_mem[idx];
                        r.stored_score      = score_mem[idx];
                        r.stored_move_code  = move_mem[idx];
                        r.stored_move_flags = flags_mem[idx];
                    end
                end
                ACT_STORE:
                begin
                    // Only a real move that is deeper than the resident entry replaces it.
                    if (w.move_flags != '0 && depth_mem[idx] < offered)
                    begin
                        // The beta test wins even when the window is inverted.
                        if (sc >= hi)
                            bound_mem[idx] = BOUND_LOWER;
                        else if (sc <= lo)
                            bound_mem[idx] = BOUND_UPPER;
                        else
                            bound_mem[idx] = BOUND_EXACT;
                        tag_mem[idx]   = w.position_hash;
                        depth_mem[idx] = offered;
                        score_mem[idx] = sc;
                        move_mem[idx]  = w.move_code;
                        flags_mem[idx] = w.move_flags;
                        tag_known[idx] = 1'b1;
                        r.written      = 1'b1;
                        replaced++;
                    end
                end
                ACT_CLEAR:
                begin
                    for (int i = 0; i < TABLE_SIZE; i++)
                        depth_mem[i] = '1;
                    clears++;
                    r.written = 1'b1;
                end
                default:
                begin
                end
            endcase
            awaited_replies.push_back(r);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_reply(logic [OUT_DATA_BITS-1:0] data);
            result_t got;
            result_t want;
            got = data[$bits(result_t)-1:0];
            if (awaited_replies.size() == 0)
            begin
                report($sformatf("result word %h arrived with nothing expected", data));
                return;
            end
            want = awaited_replies.pop_front();
            if (got.hit !== want.hit)
                report($sformatf("hit: got %0d, expected %0d", got.hit, want.hit));
            if (got.stored_depth !== want.stored_depth)
                report($sformatf("stored_depth: got %0d, expected %0d",
                                 got.stored_depth, want.stored_depth));
            if (got.bound_kind !== want.bound_kind)
                report($sformatf("bound_kind: got %0d, expected %0d",
                                 got.bound_kind, want.bound_kind));
            if (got.stored_score !== want.stored_score)
                report($sformatf("stored_score: got %0d, expected %0d",
                                 got.stored_score, want.stored_score));
            if (got.stored_move_code !== want.stored_move_code)
                report($sformatf("stored_move_code: got %h, expected %h",
                                 got.stored_move_code, want.stored_move_code));
            if (got.stored_move_flags !== want.stored_move_flags)
                report($sformatf("stored_move_flags: got %h, expected %h",
                                 got.stored_move_flags, want.stored_move_flags));
            if (got.written !== want.written)
                report($sformatf("written: got %0d, expected %0d", got.written, want.written));
        endtask
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata;
    logic [1:0]               s_axis_tuser;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;

    dptt_scoreboard book = new();

    // Cycles the receiver should hold off in one stretch; picked up by the drain process.
    int hold_request = 0;
    int cycle_count  = 0;

    // Index pool and per-index tag variants, so that random lookups hit often.
    logic [INDEX_BITS-1:0] pool_idx [POOL];
    logic [HI_BITS-1:0]    tag_hi   [POOL][3];

    depth_preferred_transposition_table DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: a lost or stuck word ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("depth_preferred_transposition_table verification failed");
            $finish;
        end
    end

    function automatic in_word_t make_word(logic [HASH_BITS-1:0] hash,
                                           logic [DEPTH_BITS-1:0] depth, bit ev,
                                           logic [SCORE_BITS-1:0] sc,
                                           logic [SCORE_BITS-1:0] al,
                                           logic [SCORE_BITS-1:0] be,
                                           logic [MOVE_BITS-1:0] mv,
                                           logic [FLAG_BITS-1:0] fl);
        in_word_t w;
        w                 = '0;
        w.position_hash   = hash;
        w.remaining_depth = depth;
        w.eval_only       = ev;
        w.score           = sc;
        w.alpha           = al;
        w.beta            = be;
        w.move_code       = mv;
        w.move_flags      = fl;
        return w;
    endfunction

    // Offers one command word after a random gap and returns once it is accepted.
    // The scoreboard is updated right here, so the next word is built on the new table.
    task automatic send_command(action_t act, in_word_t w, bit no_idle);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= act;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        book.note_command(act, w);
    endtask

    // Result side: random backpressure, bursts with tready held high, and one long
    // hold-off that lets the block fill up and stall its input.
    initial
    begin : drain
        int  gap;
        int  words;
        bit  no_idle;
        words = 0;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            no_idle = ((words / 50) % 4) == 2;
            gap     = no_idle ? 0 : $urandom_range(0, 4);
            if (hold_request > 0)
            begin
                gap          = hold_request;
                hold_request = 0;
            end
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_axis_tvalid !== 1'b1);
            book.check_reply(m_axis_tdata);
            words++;
        end
    end

    initial
    begin : stimulus
        logic [HASH_BITS-1:0]  h_top;
        logic [HASH_BITS-1:0]  h_other;
        logic [HASH_BITS-1:0]  h_last;
        logic [INDEX_BITS-1:0] idx;
        logic [HI_BITS-1:0]    upper;
        logic [SCORE_BITS-1:0] sc;
        logic [SCORE_BITS-1:0] al;
        logic [SCORE_BITS-1:0] be;
        logic [FLAG_BITS-1:0]  fl;
        action_t               act;
        int                    slot;
        int                    roll;
        int                    req;
        bit                    ev;
        bit                    no_idle;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ACT_LOOKUP;

        pool_idx[0] = '0;
        pool_idx[1] = '1;
        for (int s = 2; s < POOL; s++)
            pool_idx[s] = INDEX_BITS'($urandom_range(1, TABLE_SIZE - 2));
        for (int s = 0; s < POOL; s++)
            for (int v = 0; v < 3; v++)
                tag_hi[s][v] = HI_BITS'({$urandom, $urandom});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Index 0 is used with two different tags, index 1023 with the
        // all-ones hash. The block sweeps itself after reset; the first word simply
        // waits for tready.
        h_top   = {{HI_BITS{1'b1}}, {INDEX_BITS{1'b0}}};
        h_other = '0;
        h_last  = '1;
        // A store without a move is skipped, then a depth-zero store fills the entry.
        send_command(ACT_STORE,  make_word(h_top, 5, 0, 100, 0, 200, 16'h1234, 4'h0), 0);
        send_command(ACT_STORE,  make_word(h_top, 0, 0, 100, 0, 200, 16'h0000, 4'hF), 0);
        send_command(ACT_LOOKUP, make_word(h_top, 0, 0, 0, 0, 0, 0, 0), 0);
        // Equal depth does not replace; the deepest store with score at beta does.
        send_command(ACT_STORE,  make_word(h_top, 0, 0, 7, 0, 9, 16'h5555, 4'h2), 0);
        send_command(ACT_STORE,  make_word(h_top, 63, 0, 16'h7FFF, 16'h8000, 16'h7FFF,
                                           16'hFFFF, 4'h1), 0);
        send_command(ACT_LOOKUP, make_word(h_top, 63, 0, 0, 0, 0, 0, 0), 0);
        // Same index, other tag: no replacement, and the lookup misses on the tag.
        send_command(ACT_STORE,  make_word(h_other, 10, 1, 1, 2, 3, 16'h0101, 4'h8), 0);
        send_command(ACT_LOOKUP, make_word(h_other, 0, 1, 0, 0, 0, 0, 0), 0);
        // Score at alpha with the most negative value gives an upper bound.
        send_command(ACT_STORE,  make_word(h_last, 20, 0, 16'h8000, 16'h8000, 0,
                                           16'h8001, 4'h4), 0);
        send_command(ACT_LOOKUP, make_word(h_last, 21, 0, 0, 0, 0, 0, 0), 0);
        send_command(ACT_LOOKUP, make_word(h_last, 63, 1, 0, 0, 0, 0, 0), 0);
        // Inverted window: score below alpha but at or above beta is still a lower bound.
        send_command(ACT_STORE,  make_word(h_last, 30, 0, 50, 100, 40, 16'h7FFE, 4'hA), 0);
        send_command(ACT_LOOKUP, make_word(h_last, 30, 0, 0, 0, 0, 0, 0), 0);
        // The unused action code returns an all-zero word.
        send_command(ACT_NONE,   make_word({$urandom, $urandom}, 63, 1, 16'hFFFF, 16'hFFFF,
                                           16'hFFFF, 16'hFFFF, 4'hF), 0);
        // After a clear every entry is empty, even for eval-only lookups.
        send_command(ACT_CLEAR,  make_word(h_last, 0, 0, 0, 0, 0, 0, 0), 0);
        send_command(ACT_LOOKUP, make_word(h_top, 0, 1, 0, 0, 0, 0, 0), 0);
        send_command(ACT_LOOKUP, make_word(h_last, 0, 0, 0, 0, 0, 0, 0), 0);
        send_command(ACT_STORE,  make_word(h_top, 0, 0, 0, 0, 1, 16'h00FF, 4'h3), 0);
        send_command(ACT_LOOKUP, make_word(h_top, 0, 1, 0, 0, 0, 0, 0), 0);
        // A window strictly around the score gives an exact entry.
        send_command(ACT_STORE,  make_word(h_top, 40, 0, 0, 16'hFFFF, 1, 16'hA5A5, 4'hC), 0);
        send_command(ACT_LOOKUP, make_word(h_top, 12, 0, 0, 0, 0, 0, 0), 0);

        // Random part: mostly lookups and stores on a small index pool, rare clears and
        // no-ops. A lookup only goes to an entry whose tag has been written.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
                act = ACT_CLEAR;
            else if (roll < 5)
                act = ACT_NONE;
            else if (roll < 50)
                act = ACT_STORE;
            else
                act = ACT_LOOKUP;
            slot  = $urandom_range(0, POOL - 1);
            idx   = ($urandom_range(0, 9) == 0) ? INDEX_BITS'($urandom) : pool_idx[slot];
            upper = ($urandom_range(0, 6) == 0) ? HI_BITS'({$urandom, $urandom})
                                                : tag_hi[slot][$urandom_range(0, 2)];
            if (act == ACT_LOOKUP && !book.tag_known[idx])
            begin
                idx = pool_idx[slot];
                if (!book.tag_known[idx])
                    act = ACT_STORE;
            end
            req = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 63);
            ev  = ($urandom_range(0, 3) == 0);
            sc  = SCORE_BITS'($urandom);
            case ($urandom_range(0, 3))
                0:
                begin
                    al = sc - SCORE_BITS'($urandom_range(0, 3));
                    be = sc + SCORE_BITS'($urandom_range(0, 3));
                end
                1:
                begin
                    al = SCORE_BITS'($urandom);
                    be = SCORE_BITS'($urandom);
                end
                2:
                begin
                    al = sc + SCORE_BITS'($urandom_range(1, 50));
                    be = sc - SCORE_BITS'($urandom_range(0, 50));
                end
                default:
                begin
                    al = sc - SCORE_BITS'($urandom_range(1, 500));
                    be = sc + SCORE_BITS'($urandom_range(1, 500));
                end
            endcase
            fl      = ($urandom_range(0, 6) == 0) ? 4'h0 : FLAG_BITS'($urandom_range(1, 15));
            no_idle = ((n / 40) % 4) == 3;
            if (n == 300)
                hold_request = 500;
            send_command(act, make_word({upper, idx}, DEPTH_BITS'(req), ev, sc, al, be,
                                        MOVE_BITS'($urandom), fl),
                         no_idle);
        end
        s_axis_tvalid <= 1'b0;

        while (book.awaited_replies.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Run covered %0d lookups (%0d hits), %0d replacing stores and %0d clears",
                 book.lookups, book.hits, book.replaced, book.clears);
        $display("in %0d cycles, with random backpressure and one long output stall.",
                 cycle_count);
        if (book.mismatches == 0 && book.awaited_replies.size() == 0)
            $display("depth_preferred_transposition_table verification clean");
        else
            $display("depth_preferred_transposition_table verification failed");
        $finish;
    end
endmodule

### sim.f
hdl/dptt_pkg.sv
hdl/dptt_ram.sv
hdl/dptt_front.sv
hdl/dptt_back.sv
hdl/depth_preferred_transposition_table.sv
tb/tb.sv
